// ===== hw/rtl/tbd_pkg.sv =====
package tbd_pkg;

    localparam int NUM_BANDS_DEF = 31;
    localparam int MEAN_TABLE_DEPTH_DEF = 256;

    localparam int LEVEL_W = 16;
    localparam int CORR_W = 9;
    localparam int DIFF_RANGE_W = 11;
    localparam int TOL_W = 12;
    localparam int BAND_IDX_W = 6;
    localparam int KIND_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ANCHOR_COUNT = 33;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPECTRUM_KIND = 2'd0,
        CFG_LOW_TOL       = 2'd1,
        CFG_HIGH_TOL      = 2'd2,
        CFG_SWITCH_BAND   = 2'd3
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_THIRD_OCTAVE = 2'd0,
        KIND_LINEAR       = 2'd1,
        KIND_OCTAVE       = 2'd2,
        KIND_UNUSED       = 2'd3
    } spectrum_kind_t;

    localparam logic [KIND_W-1:0] KIND_RESET = KIND_THIRD_OCTAVE;
    localparam logic [TOL_W-1:0] LOW_TOL_RESET = 12'd640;
    localparam logic [TOL_W-1:0] HIGH_TOL_RESET = 12'd320;
    localparam logic [BAND_IDX_W-1:0] SWITCH_BAND_RESET = 6'd13;

    typedef logic signed [CORR_W-1:0] corr_t;

    // Mean correction at each whole dB of level difference, 1/64 dB units.
    localparam corr_t ANCHOR_CORR [ANCHOR_COUNT] = '{
           9'sd0,  -9'sd30,  -9'sd57,  -9'sd80, -9'sd100, -9'sd116, -9'sd130,
        -9'sd142, -9'sd152, -9'sd160, -9'sd166, -9'sd171, -9'sd176, -9'sd179,
        -9'sd182, -9'sd184, -9'sd186, -9'sd187, -9'sd188, -9'sd189, -9'sd190,
        -9'sd190, -9'sd191, -9'sd191, -9'sd192, -9'sd192, -9'sd192, -9'sd192,
        -9'sd192, -9'sd192, -9'sd192, -9'sd192, -9'sd192
    };

    // Interpolated correction for a difference in 1/64 dB below 2048.
    function automatic corr_t corr_at(input logic [DIFF_RANGE_W:0] di);
        logic [5:0] n;
        logic [5:0] f;
        logic [CORR_W-1:0] drop;
        logic [CORR_W+6:0] scaled;
        corr_t result;
        begin
            n = di[DIFF_RANGE_W:6];
            f = di[5:0];
            if (n >= 6'(ANCHOR_COUNT - 1))
            begin
                result = ANCHOR_CORR[ANCHOR_COUNT-1];
            end
            else
            begin
                drop = CORR_W'(ANCHOR_CORR[n] - ANCHOR_CORR[n+1]);
                scaled = ((CORR_W+7)'(drop) * (CORR_W+7)'(f) + (CORR_W+7)'(32)) >> 6;
                result = ANCHOR_CORR[n] - corr_t'(scaled);
            end
            return result;
        end
    endfunction

endpackage

// ===== hw/rtl/tonal_band_detector.sv =====
// A band request is registered at the input stage, and the result for a spectrum
// is registered at the output when its last band leaves the input stage.
// Throughput: one band per cycle; the only hold-off comes from a stalled result.
// The two-level energetic means use a constant correction table read twice per cycle.
// Reset clears the pipeline valids, the band count and the tone flag and loads
// the configuration registers with their default values.
module tonal_band_detector
    import tbd_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF,
    parameter int MEAN_TABLE_DEPTH = MEAN_TABLE_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [LEVEL_W-1:0] band_level,
    input  logic                    last_band,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    tonal
);

    localparam int CNT_W = $clog2(NUM_BANDS + 1);
    localparam int CMP_W = ((CNT_W > BAND_IDX_W) ? CNT_W : BAND_IDX_W) + 1;
    localparam int IDX_W = $clog2(MEAN_TABLE_DEPTH);
    localparam int PROD_W = DIFF_RANGE_W + $clog2(MEAN_TABLE_DEPTH + 1);
    localparam int DIFF_W = LEVEL_W + 1;
    localparam int MEAN_W = LEVEL_W + 1;
    localparam int EXCESS_W = LEVEL_W + 2;

    logic [KIND_W-1:0]     kind_reg;
    logic [TOL_W-1:0]      low_tol_reg;
    logic [TOL_W-1:0]      high_tol_reg;
    logic [BAND_IDX_W-1:0] switch_band_reg;

    logic                       s1_valid_reg;
    logic signed [LEVEL_W-1:0]  s1_level_reg;
    logic                       s1_last_reg;

    logic signed [LEVEL_W-1:0]  window_reg [4];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       tone_reg;
    logic                       tone_next;
    logic                       out_valid_reg;
    logic                       tonal_reg;
    logic                       advance;
    logic                       take_band;
    logic                       test_center;
    logic                       hit;
    logic [TOL_W-1:0]           tol;
    logic signed [MEAN_W-1:0]   left_mean;
    logic signed [MEAN_W-1:0]   right_mean;
    logic signed [EXCESS_W-1:0] left_excess;
    logic signed [EXCESS_W-1:0] right_excess;

    corr_t corr_rom [MEAN_TABLE_DEPTH];

    for (genvar i = 0; i < MEAN_TABLE_DEPTH; i++)
    begin : g_rom
        localparam int DI = (i * 2048) / MEAN_TABLE_DEPTH;
        assign corr_rom[i] = corr_at((DIFF_RANGE_W+1)'(DI));
    end

    function automatic logic signed [MEAN_W-1:0] mean_of(
        input logic signed [LEVEL_W-1:0] p,
        input logic signed [LEVEL_W-1:0] q,
        input corr_t rom [MEAN_TABLE_DEPTH]
    );
        logic signed [DIFF_W-1:0] dp;
        logic [DIFF_W-1:0]        d;
        logic signed [LEVEL_W-1:0] hi;
        logic [PROD_W-1:0]        prod;
        logic [PROD_W-1:0]        idx_full;
        logic [IDX_W-1:0]         idx;
        corr_t                    corr;
        begin
            dp = DIFF_W'(p) - DIFF_W'(q);
            hi = (p > q) ? p : q;
            d = dp[DIFF_W-1] ? DIFF_W'(-dp) : DIFF_W'(dp);
            prod = PROD_W'(d[DIFF_RANGE_W-1:0]) * PROD_W'(MEAN_TABLE_DEPTH);
            idx_full = prod >> DIFF_RANGE_W;
            if (idx_full >= PROD_W'(MEAN_TABLE_DEPTH))
            begin
                idx = IDX_W'(MEAN_TABLE_DEPTH - 1);
            end
            else
            begin
                idx = idx_full[IDX_W-1:0];
            end
            if (d >= DIFF_W'(2048))
            begin
                corr = ANCHOR_CORR[ANCHOR_COUNT-1];
            end
            else
            begin
                corr = rom[idx];
            end
            return MEAN_W'(hi) + MEAN_W'(corr);
        end
    endfunction

    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign tonal = tonal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_RESET;
            low_tol_reg <= LOW_TOL_RESET;
            high_tol_reg <= HIGH_TOL_RESET;
            switch_band_reg <= SWITCH_BAND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPECTRUM_KIND: kind_reg <= cfg_data[KIND_W-1:0];
                CFG_LOW_TOL:       low_tol_reg <= cfg_data[TOL_W-1:0];
                CFG_HIGH_TOL:      high_tol_reg <= cfg_data[TOL_W-1:0];
                CFG_SWITCH_BAND:   switch_band_reg <= cfg_data[BAND_IDX_W-1:0];
                default:           kind_reg <= kind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_level_reg <= band_level;
            s1_last_reg <= last_band;
        end
    end

    assign take_band = s1_valid_reg && (count_reg < CNT_W'(NUM_BANDS));
    assign test_center = take_band && (count_reg >= CNT_W'(4));

    always_comb
    begin
        left_mean = mean_of(window_reg[0], window_reg[1], corr_rom);
        right_mean = mean_of(window_reg[3], s1_level_reg, corr_rom);
        if (CMP_W'(count_reg) > CMP_W'(switch_band_reg) + CMP_W'(2))
        begin
            tol = high_tol_reg;
        end
        else
        begin
            tol = low_tol_reg;
        end
        left_excess = EXCESS_W'(window_reg[2]) - EXCESS_W'(left_mean);
        right_excess = EXCESS_W'(window_reg[2]) - EXCESS_W'(right_mean);
        hit = (left_excess > $signed(EXCESS_W'(tol)))
            && (right_excess > $signed(EXCESS_W'(tol)));
    end

    always_comb
    begin
        count_next = count_reg;
        tone_next = tone_reg;
        if (s1_valid_reg && advance)
        begin
            if (take_band)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (test_center && hit)
            begin
                tone_next = 1'b1;
            end
            if (s1_last_reg)
            begin
                count_next = '0;
                tone_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tone_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            tone_reg <= tone_next;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take_band)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= window_reg[3];
            window_reg[3] <= s1_level_reg;
        end
        if (advance && s1_valid_reg && s1_last_reg)
        begin
            tonal_reg <= (tone_reg || (test_center && hit))
                && (kind_reg == KIND_THIRD_OCTAVE);
        end
    end

endmodule

// ===== tb/sv/tonal_band_detector_tb.sv =====
module tonal_band_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbd_pkg::*;

    localparam int NUM_BANDS_TB = 31;
    localparam int TABLE_DEPTH = 256;
    localparam int ANCHORS = 33;
    localparam int HALF_PERIOD = 5;
    localparam int RUN_LIMIT = 300000;
    localparam int PHASES = 12;
    localparam int BANDS_PER_PHASE = 102;
    localparam int DRAIN_CYCLES = 6;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed {
        logic                      is_write;
        cfg_reg_t                  reg_idx;
        logic [CFG_DATA_W-1:0]     reg_val;
        logic signed [LEVEL_W-1:0] level;
        logic                      last;
        logic                      typed;
        logic                      tonal;
    } band_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [LEVEL_W-1:0] band_level = '0;
    logic                      last_band = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      tonal;

    // Correction of the energetic mean at each whole dB of difference.
    int mean_anchor [ANCHORS] = '{
           0,  -30,  -57,  -80, -100, -116, -130, -142, -152, -160, -166,
        -171, -176, -179, -182, -184, -186, -187, -188, -189, -190, -190,
        -191, -191, -192, -192, -192, -192, -192, -192, -192, -192, -192
    };

    spectrum_kind_t        kind_cfg = KIND_THIRD_OCTAVE;
    logic [TOL_W-1:0]      low_tol_cfg = 12'd640;
    logic [TOL_W-1:0]      high_tol_cfg = 12'd320;
    logic [BAND_IDX_W-1:0] switch_cfg = 6'd13;

    int window_lvl [4] = '{0, 0, 0, 0};
    int bands_taken = 0;
    bit tone_seen = 1'b0;

    bit expected_tonal [$];
    int mismatches = 0;
    int cycles = 0;
    int stall_left = 0;
    int stall_draw;
    bit want_tonal;
    bit quiet = 1'b0;

    band_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd1000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sh8000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sh8000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sh7FFF, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sh8000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sh8000, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd5000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b1, 1'b1, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd640,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b1, 1'b1, 1'b0},
        '{1'b1, CFG_SPECTRUM_KIND, 12'd1, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd1000, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b1, 1'b1, 1'b0},
        '{1'b1, CFG_SPECTRUM_KIND, 12'd0, 16'sd0,    1'b0, 1'b0, 1'b0}
    };

    tonal_band_detector #(
        .NUM_BANDS(NUM_BANDS_TB),
        .MEAN_TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .band_level(band_level),
        .last_band(last_band),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .tonal(tonal)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int table_correction(int idx);
        int di;
        int n;
        int f;
        int drop;
        di = (idx * 2048) / TABLE_DEPTH;
        n = di >> 6;
        f = di & 63;
        if (n >= ANCHORS - 1)
        begin
            return mean_anchor[ANCHORS-1];
        end
        drop = mean_anchor[n] - mean_anchor[n+1];
        return mean_anchor[n] - ((drop * f + 32) >> 6);
    endfunction

    function automatic int energetic_mean(int p, int q);
        int hi;
        int d;
        int idx;
        hi = (p > q) ? p : q;
        d = (p > q) ? p - q : q - p;
        if (d >= 2048)
        begin
            return hi + mean_anchor[ANCHORS-1];
        end
        idx = (d * TABLE_DEPTH) >> 11;
        if (idx >= TABLE_DEPTH)
        begin
            idx = TABLE_DEPTH - 1;
        end
        return hi + table_correction(idx);
    endfunction

    function automatic void predict_band(input int level, input bit last,
                                         output bit ends, output bit tone_flag);
        int left;
        int right;
        int center;
        int tol;
        ends = last;
        tone_flag = 1'b0;
        if (bands_taken < NUM_BANDS_TB)
        begin
            if (bands_taken >= 4)
            begin
                center = bands_taken - 2;
                left = energetic_mean(window_lvl[0], window_lvl[1]);
                right = energetic_mean(window_lvl[3], level);
                tol = (center > int'(switch_cfg)) ? int'(high_tol_cfg) : int'(low_tol_cfg);
                if ((window_lvl[2] - left) > tol && (window_lvl[2] - right) > tol)
                begin
                    tone_seen = 1'b1;
                end
            end
            window_lvl[0] = window_lvl[1];
            window_lvl[1] = window_lvl[2];
            window_lvl[2] = window_lvl[3];
            window_lvl[3] = level;
            bands_taken++;
        end
        if (last)
        begin
            tone_flag = tone_seen && (kind_cfg == KIND_THIRD_OCTAVE);
            window_lvl = '{0, 0, 0, 0};
            bands_taken = 0;
            tone_seen = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
        begin
            $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        end
        mismatches++;
    endtask

    task automatic send_band(input logic signed [LEVEL_W-1:0] level, input bit last,
                             input bit typed, input bit typed_tonal);
        int gap;
        bit ends;
        bit tone_flag;
        bit want;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        band_level <= level;
        last_band <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_band(int'(level), last, ends, tone_flag);
        if (ends)
        begin
            want = typed ? typed_tonal : tone_flag;
            expected_tonal = {expected_tonal, want};
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_tonal.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SPECTRUM_KIND: kind_cfg = spectrum_kind_t'(val[KIND_W-1:0]);
            CFG_LOW_TOL:       low_tol_cfg = val[TOL_W-1:0];
            CFG_HIGH_TOL:      high_tol_cfg = val[TOL_W-1:0];
            CFG_SWITCH_BAND:   switch_cfg = val[BAND_IDX_W-1:0];
            default:           ;
        endcase
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tonal.size() == 0)
                begin
                    report_mismatch("tonal result with no request pending", -1, int'(tonal));
                end
                else
                begin
                    want_tonal = expected_tonal.pop_front();
                    if (tonal !== want_tonal)
                    begin
                        report_mismatch("tonal", int'(want_tonal), int'(tonal));
                    end
                end
                stall_draw = quiet ? 0 : $urandom_range(0, 5);
                stall_left <= stall_draw;
                out_stall <= (stall_draw != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
        end
    end

    initial
    begin
        int sent;
        int nb;
        int base;
        int spread;
        int peak_at;
        int peak;
        int lvl;
        bit noisy;
        bit twin;
        int shape;
        logic [CFG_DATA_W-1:0] kind_val;
        logic [CFG_DATA_W-1:0] low_val;
        logic [CFG_DATA_W-1:0] high_val;
        logic [CFG_DATA_W-1:0] switch_val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].is_write)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                cfg_write <= 1'b0;
            end
            else
            begin
                send_band(directed_rows[i].level, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].tonal);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    kind_val = 12'(KIND_THIRD_OCTAVE);
                    low_val = 12'd0;
                    high_val = 12'd0;
                    switch_val = 12'd0;
                end
                1:
                begin
                    kind_val = 12'(KIND_THIRD_OCTAVE);
                    low_val = 12'd4095;
                    high_val = 12'd4095;
                    switch_val = 12'd63;
                end
                2:
                begin
                    kind_val = 12'(KIND_UNUSED);
                    low_val = 12'($urandom_range(0, 900));
                    high_val = 12'($urandom_range(0, 900));
                    switch_val = 12'($urandom_range(0, 31));
                end
                3:
                begin
                    kind_val = 12'(KIND_OCTAVE);
                    low_val = 12'($urandom_range(0, 900));
                    high_val = 12'($urandom_range(0, 900));
                    switch_val = 12'd63;
                end
                default:
                begin
                    kind_val = ($urandom_range(0, 9) < 8) ? 12'(KIND_THIRD_OCTAVE)
                                                          : 12'($urandom_range(1, 3));
                    low_val = 12'($urandom_range(0, 900));
                    high_val = 12'($urandom_range(0, 900));
                    switch_val = ($urandom_range(0, 5) == 0) ? 12'd63
                                                              : 12'($urandom_range(0, 31));
                end
            endcase
            write_reg(CFG_SPECTRUM_KIND, kind_val);
            write_reg(CFG_LOW_TOL, low_val);
            write_reg(CFG_HIGH_TOL, high_val);
            write_reg(CFG_SWITCH_BAND, switch_val);
            cfg_write <= 1'b0;
            quiet = (phase % 4 == 2);

            sent = 0;
            while (sent < BANDS_PER_PHASE)
            begin
                shape = $urandom_range(0, 9);
                if (shape == 0)
                begin
                    nb = $urandom_range(1, 4);
                end
                else if (shape == 1)
                begin
                    nb = $urandom_range(32, 40);
                end
                else if (shape < 6)
                begin
                    nb = NUM_BANDS_TB;
                end
                else
                begin
                    nb = $urandom_range(5, 30);
                end
                noisy = ($urandom_range(0, 7) == 0);
                twin = ($urandom_range(0, 3) == 0);
                base = int'($urandom_range(0, 8000)) - 2000;
                spread = $urandom_range(0, 2500);
                peak_at = $urandom_range(0, nb - 1);
                peak = $urandom_range(0, 1500);
                for (int b = 0; b < nb; b++)
                begin
                    if (noisy)
                    begin
                        lvl = int'($urandom_range(0, 65535)) - 32768;
                    end
                    else
                    begin
                        lvl = base + int'($urandom_range(0, spread)) - spread / 2;
                        if (b == peak_at)
                        begin
                            lvl = lvl + peak;
                        end
                        else if (twin && b == peak_at + 1)
                        begin
                            lvl = lvl + peak / 2;
                        end
                    end
                    if (lvl > 32767)
                    begin
                        lvl = 32767;
                    end
                    if (lvl < -32768)
                    begin
                        lvl = -32768;
                    end
                    send_band(LEVEL_W'(lvl), (b == nb - 1), 1'b0, 1'b0);
                    sent++;
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    in_valid <= 1'b0;
                    while (expected_tonal.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_tonal.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES * 2) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== tonal_band_detector.f =====
hw/rtl/tbd_pkg.sv
hw/rtl/tonal_band_detector.sv
tb/sv/tonal_band_detector_tb.sv
